// ----- design/htw_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_pkg - shared types for the hierarchical timer wheel
// Request/result payloads, codes, controller states and the
// command/status bundles between controller and datapath.
// ----------------------------------------------------------------------------
package htw_pkg;

    localparam int PTR_W = 7;
    localparam logic [PTR_W-1:0] PTR_NIL = 7'd127;
    localparam int CNT_W = 7;
    localparam int HDL_W = 6;
    localparam int DLY_W = 32;

    typedef enum logic [1:0] {
        OP_SET   = 2'd0,
        OP_CLEAR = 2'd1,
        OP_TICK  = 2'd2
    } op_t;

    typedef enum logic [1:0] {
        KIND_SET     = 2'd0,
        KIND_CLEAR   = 2'd1,
        KIND_EXPIRED = 2'd2,
        KIND_QUIET   = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        STAT_OK         = 2'd0,
        STAT_FULL       = 2'd1,
        STAT_NOT_ACTIVE = 2'd2
    } stat_t;

    typedef enum logic [1:0] {
        ID_ZERO   = 2'd0,
        ID_ENTRY  = 2'd1,
        ID_HANDLE = 2'd2
    } id_src_t;

    typedef enum logic [4:0] {
        S_INIT,
        S_IDLE,
        S_SET,
        S_PUSH1,
        S_PUSH2,
        S_CLR,
        S_UNL1,
        S_UNL2,
        S_UNL3,
        S_TK_HEAD,
        S_TK_CHK,
        S_TK_ADV,
        S_CAS_RD,
        S_CAS_CLR,
        S_CAS_WALK,
        S_CAS_PICK
    } state_t;

    typedef struct packed {
        logic [1:0]       op;
        logic [DLY_W-1:0] delay_ticks;
        logic [HDL_W-1:0] handle;
    } req_t;

    typedef struct packed {
        logic [1:0]       kind;
        logic [HDL_W-1:0] timer_id;
        logic [1:0]       status;
        logic [CNT_W-1:0] active_count;
        logic             last;
    } res_t;

    typedef struct packed {
        logic [PTR_W-1:0] head;
        logic [PTR_W-1:0] tail;
    } bkt_t;

    typedef struct packed {
        state_t  step;
        logic    take;
        logic    emit;
        kind_t   kind;
        stat_t   stat;
        id_src_t id_src;
        logic    last;
    } cmd_t;

    typedef struct packed {
        logic init_last;
        logic pool_full;
        logic clr_ok;
        logic tail_ok;
        logic wrap;
        logic walk_ok;
        logic cas_stop;
        logic fire_last;
    } sts_t;

endpackage
`default_nettype wire

// ----- design/htw_ctrl.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_ctrl - sequencer for the timer wheel
// Walks each request through its memory steps and decides result emission.
// ----------------------------------------------------------------------------
module htw_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    input  wire logic [1:0]    req_op,
    input  wire htw_pkg::sts_t sts,
    output htw_pkg::cmd_t      cmd,
    output logic               busy
);
    import htw_pkg::*;

    state_t state_reg, state_next;
    op_t    mode_reg, mode_next;
    logic   fired_reg, fired_next;
    logic   take;

    assign take = (state_reg == S_IDLE) && start;
    assign busy = (state_reg != S_IDLE);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_INIT;
            mode_reg  <= OP_TICK;
            fired_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            mode_reg  <= mode_next;
            fired_reg <= fired_next;
        end
    end

    // mode and fired flag
    always_comb
    begin
        mode_next  = mode_reg;
        fired_next = fired_reg;
        if (take)
        begin
            fired_next = 1'b0;
            if (req_op == OP_SET)
                mode_next = OP_SET;
            else if (req_op == OP_CLEAR)
                mode_next = OP_CLEAR;
            else
                mode_next = OP_TICK;
        end
        if (state_reg == S_UNL3 && mode_reg == OP_TICK)
            fired_next = 1'b1;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_INIT:     if (sts.init_last) state_next = S_IDLE;
            S_IDLE:
            begin
                if (start)
                begin
                    if (req_op == OP_SET)
                        state_next = S_SET;
                    else if (req_op == OP_CLEAR)
                        state_next = S_CLR;
                    else
                        state_next = S_TK_HEAD;
                end
            end
            S_SET:      state_next = sts.pool_full ? S_IDLE : S_PUSH1;
            S_PUSH1:    state_next = S_PUSH2;
            S_PUSH2:    state_next = (mode_reg == OP_SET) ? S_IDLE : S_CAS_WALK;
            S_CLR:      state_next = sts.clr_ok ? S_UNL1 : S_IDLE;
            S_UNL1:     state_next = S_UNL2;
            S_UNL2:     state_next = S_UNL3;
            S_UNL3:     state_next = (mode_reg == OP_CLEAR) ? S_IDLE : S_TK_HEAD;
            S_TK_HEAD:  state_next = S_TK_CHK;
            S_TK_CHK:   state_next = sts.tail_ok ? S_UNL1 : S_TK_ADV;
            S_TK_ADV:   state_next = sts.wrap ? S_CAS_RD : S_IDLE;
            S_CAS_RD:   state_next = S_CAS_CLR;
            S_CAS_CLR:  state_next = S_CAS_WALK;
            S_CAS_WALK:
            begin
                if (sts.walk_ok)
                    state_next = S_CAS_PICK;
                else if (sts.cas_stop)
                    state_next = S_IDLE;
                else
                    state_next = S_CAS_RD;
            end
            S_CAS_PICK: state_next = S_PUSH1;
            default:    state_next = S_IDLE;
        endcase
    end

    // command outputs
    always_comb
    begin
        cmd        = '0;
        cmd.step   = state_reg;
        cmd.take   = take;
        cmd.kind   = KIND_QUIET;
        cmd.stat   = STAT_OK;
        cmd.id_src = ID_ZERO;
        cmd.last   = 1'b1;
        unique case (state_reg)
            S_SET:
            begin
                cmd.emit = sts.pool_full;
                cmd.kind = KIND_SET;
                cmd.stat = STAT_FULL;
            end
            S_PUSH2:
            begin
                cmd.emit   = (mode_reg == OP_SET);
                cmd.kind   = KIND_SET;
                cmd.id_src = ID_ENTRY;
            end
            S_CLR:
            begin
                cmd.emit   = !sts.clr_ok;
                cmd.kind   = KIND_CLEAR;
                cmd.stat   = STAT_NOT_ACTIVE;
                cmd.id_src = ID_HANDLE;
            end
            S_UNL3:
            begin
                cmd.emit   = 1'b1;
                cmd.id_src = ID_ENTRY;
                if (mode_reg == OP_CLEAR)
                    cmd.kind = KIND_CLEAR;
                else
                begin
                    cmd.kind = KIND_EXPIRED;
                    cmd.last = sts.fire_last;
                end
            end
            S_TK_ADV:   cmd.emit = !fired_reg;
            default:    cmd.emit = 1'b0;
        endcase
    end

endmodule
`default_nettype wire

// ----- design/htw_dpath.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// htw_dpath - timer wheel datapath
// Entry and bucket memories, pool flags, position, tick count and result.
// ----------------------------------------------------------------------------
module htw_dpath #(
    parameter int LEVEL_BITS = 8,
    parameter int NUM_LEVELS = 4,
    parameter int POOL_SIZE  = 64
) (
    input  wire logic           clk,
    input  wire logic           rst_n,
    input  wire htw_pkg::req_t  request,
    input  wire htw_pkg::cmd_t  cmd,
    output htw_pkg::sts_t       sts,
    output logic                done,
    output htw_pkg::res_t       result
);
    import htw_pkg::*;

    localparam int LB     = LEVEL_BITS;
    localparam int NB     = 1 << LB;
    localparam int NTOTAL = NUM_LEVELS * NB;
    localparam int BKW    = $clog2(NTOTAL);
    localparam int AW     = BKW + 3;
    localparam int IW     = LB + 1;
    localparam int EW     = $clog2(POOL_SIZE);
    localparam int LVW    = (NUM_LEVELS > 1) ? $clog2(NUM_LEVELS) : 1;
    localparam logic [63:0] MASK64 = 64'(NB - 1);

    // memories
    bkt_t             bkt_mem [NTOTAL];
    logic [DLY_W-1:0] exp_mem [POOL_SIZE];
    logic [BKW-1:0]   ebk_mem [POOL_SIZE];
    logic [PTR_W-1:0] nxt_mem [POOL_SIZE];
    logic [PTR_W-1:0] prv_mem [POOL_SIZE];

    bkt_t             bkt_q;
    logic [DLY_W-1:0] exp_q;
    logic [BKW-1:0]   ebk_q;
    logic [PTR_W-1:0] nxt_q, prv_q;

    logic             bkt_we, exp_we, ebk_we, nxt_we, prv_we;
    logic [BKW-1:0]   bkt_wa, bkt_ra;
    bkt_t             bkt_wd;
    logic [EW-1:0]    exp_wa, ebk_wa, nxt_wa, prv_wa, ent_ra;
    logic [DLY_W-1:0] exp_wd;
    logic [BKW-1:0]   ebk_wd;
    logic [PTR_W-1:0] nxt_wd, prv_wd;

    // registers
    logic [POOL_SIZE-1:0] active_reg, active_next;
    logic [CNT_W-1:0]     cnt_reg, cnt_next;
    logic [DLY_W-1:0]     pos_reg, pos_next;
    logic [DLY_W-1:0]     now_reg, now_next;
    logic [LVW-1:0]       lvl_reg, lvl_next;
    logic [BKW-1:0]       clr_reg, clr_next;
    logic                 done_reg, done_next;
    res_t                 res_reg, res_next;
    logic [EW-1:0]        e_reg, e_next;
    logic [BKW-1:0]       b_reg, b_next;
    logic [PTR_W-1:0]     p_reg, p_next, n_reg, n_next, t_reg, t_next;
    logic [DLY_W-1:0]     delay_reg, delay_next;
    logic [HDL_W-1:0]     handle_reg, handle_next;

    // helpers
    logic [EW-1:0]    free_idx;
    logic             free_found;
    logic [LB-1:0]    cas_dig;
    logic [BKW-1:0]   cas_b;
    logic [AW-1:0]    cas_wide;
    logic [DLY_W-1:0] pos_inc;
    logic [DLY_W-1:0] rem;

    function automatic logic ptr_ok(input logic [PTR_W-1:0] p);
        ptr_ok = (p < PTR_W'(POOL_SIZE));
    endfunction

    // level and slot for a timer that is due in ticks from now
    function automatic logic [BKW-1:0] pick_bucket(input logic [DLY_W-1:0] ticks,
                                                   input logic [DLY_W-1:0] pos);
        logic [63:0]   t64;
        logic [63:0]   p64;
        logic [2:0]    lvl;
        logic          found;
        logic [IW-1:0] idx;
        logic [IW-1:0] dig;
        logic [AW-1:0] addr;
        begin
            t64   = {32'd0, ticks};
            p64   = {32'd0, pos};
            lvl   = 3'(NUM_LEVELS);
            found = 1'b0;
            idx   = '0;
            dig   = '0;
            for (int l = 0; l < NUM_LEVELS; l++)
            begin
                if (!found && (t64 >> (LB * (l + 1))) == 64'd0)
                begin
                    found = 1'b1;
                    lvl   = 3'(l);
                    idx   = IW'((t64 >> (LB * l)) & MASK64);
                end
            end
            for (int l = 0; l <= NUM_LEVELS; l++)
            begin
                if (lvl == 3'(l))
                    dig = IW'((p64 >> (LB * l)) & MASK64);
            end
            idx = idx + dig;
            if (idx >= IW'(NB))
            begin
                lvl = lvl + 3'd1;
                idx = '0;
            end
            if (lvl >= 3'(NUM_LEVELS))
            begin
                lvl = 3'(NUM_LEVELS - 1);
                idx = IW'(NB - 1);
            end
            addr = (AW'(lvl) << LB) | AW'(idx);
            pick_bucket = addr[BKW-1:0];
        end
    endfunction

    // first free pool entry
    always_comb
    begin
        free_idx   = '0;
        free_found = 1'b0;
        for (int i = 0; i < POOL_SIZE; i++)
        begin
            if (!free_found && !active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = EW'(i);
            end
        end
    end

    // cascade bucket for the current level
    always_comb
    begin
        cas_dig = '0;
        for (int l = 1; l < NUM_LEVELS; l++)
        begin
            if (lvl_reg == LVW'(l))
                cas_dig = LB'(({32'd0, pos_reg} >> (LB * l)) & MASK64);
        end
        cas_wide = (AW'(lvl_reg) << LB) | AW'(cas_dig);
        cas_b    = cas_wide[BKW-1:0];
    end

    assign pos_inc = pos_reg + 32'd1;
    assign rem     = (exp_q == now_reg) ? 32'd1 : (exp_q - now_reg);

    always_comb
    begin
        sts           = '0;
        sts.init_last = (clr_reg == BKW'(NTOTAL - 1));
        sts.pool_full = !free_found;
        sts.clr_ok    = (handle_reg < HDL_W'(POOL_SIZE - 1)
                         || handle_reg == HDL_W'(POOL_SIZE - 1))
                        && active_reg[handle_reg[EW-1:0]];
        sts.tail_ok   = ptr_ok(bkt_q.tail);
        sts.wrap      = (NUM_LEVELS > 1) && (pos_inc[LB-1:0] == '0);
        sts.walk_ok   = ptr_ok(t_reg);
        sts.cas_stop  = (cas_dig != '0) || (lvl_reg == LVW'(NUM_LEVELS - 1));
        sts.fire_last = !ptr_ok(p_reg);
    end

    // step actions
    always_comb
    begin
        bkt_we = 1'b0; bkt_wa = b_reg; bkt_wd = bkt_q; bkt_ra = b_reg;
        exp_we = 1'b0; exp_wa = e_reg; exp_wd = now_reg + delay_reg;
        ebk_we = 1'b0; ebk_wa = e_reg; ebk_wd = b_reg;
        nxt_we = 1'b0; nxt_wa = e_reg; nxt_wd = bkt_q.head;
        prv_we = 1'b0; prv_wa = e_reg; prv_wd = PTR_NIL;
        ent_ra = e_reg;

        active_next = active_reg;
        cnt_next    = cnt_reg;
        pos_next    = pos_reg;
        now_next    = now_reg;
        lvl_next    = lvl_reg;
        clr_next    = clr_reg;
        e_next      = e_reg;
        b_next      = b_reg;
        p_next      = p_reg;
        n_next      = n_reg;
        t_next      = t_reg;
        delay_next  = delay_reg;
        handle_next = handle_reg;

        if (cmd.take)
        begin
            delay_next  = (request.delay_ticks == '0) ? 32'd1 : request.delay_ticks;
            handle_next = request.handle;
        end

        unique case (cmd.step)
            S_INIT:
            begin
                bkt_we   = 1'b1;
                bkt_wa   = clr_reg;
                bkt_wd   = '{head: PTR_NIL, tail: PTR_NIL};
                clr_next = clr_reg + BKW'(1);
            end
            S_SET:
            begin
                if (free_found)
                begin
                    active_next[free_idx] = 1'b1;
                    cnt_next = cnt_reg + CNT_W'(1);
                    e_next   = free_idx;
                    exp_we   = 1'b1;
                    exp_wa   = free_idx;
                    b_next   = pick_bucket(delay_reg, pos_reg);
                end
            end
            S_PUSH1:
            begin
                bkt_ra = b_reg;
                prv_we = 1'b1;
                prv_wa = e_reg;
                prv_wd = PTR_NIL;
            end
            S_PUSH2:
            begin
                nxt_we      = 1'b1;
                nxt_wd      = bkt_q.head;
                ebk_we      = 1'b1;
                bkt_we      = 1'b1;
                bkt_wd.head = PTR_W'(e_reg);
                bkt_wd.tail = ptr_ok(bkt_q.head) ? bkt_q.tail : PTR_W'(e_reg);
                if (ptr_ok(bkt_q.head))
                begin
                    prv_we = 1'b1;
                    prv_wa = bkt_q.head[EW-1:0];
                    prv_wd = PTR_W'(e_reg);
                end
            end
            S_CLR:
            begin
                if (sts.clr_ok)
                begin
                    active_next[handle_reg[EW-1:0]] = 1'b0;
                    cnt_next = cnt_reg - CNT_W'(1);
                    e_next   = handle_reg[EW-1:0];
                end
            end
            S_UNL1:     ent_ra = e_reg;
            S_UNL2:
            begin
                b_next = ebk_q;
                p_next = prv_q;
                n_next = nxt_q;
                bkt_ra = ebk_q;
                if (ptr_ok(prv_q))
                begin
                    nxt_we = 1'b1;
                    nxt_wa = prv_q[EW-1:0];
                    nxt_wd = nxt_q;
                end
                if (ptr_ok(nxt_q))
                begin
                    prv_we = 1'b1;
                    prv_wa = nxt_q[EW-1:0];
                    prv_wd = prv_q;
                end
            end
            S_UNL3:
            begin
                bkt_we = 1'b1;
                bkt_wa = b_reg;
                bkt_wd = bkt_q;
                if (!ptr_ok(p_reg))
                    bkt_wd.head = n_reg;
                if (!ptr_ok(n_reg))
                    bkt_wd.tail = p_reg;
            end
            S_TK_HEAD:  bkt_ra = BKW'(pos_reg[LB-1:0]);
            S_TK_CHK:
            begin
                if (ptr_ok(bkt_q.tail))
                begin
                    e_next = bkt_q.tail[EW-1:0];
                    active_next[bkt_q.tail[EW-1:0]] = 1'b0;
                    cnt_next = cnt_reg - CNT_W'(1);
                end
            end
            S_TK_ADV:
            begin
                pos_next = pos_inc;
                now_next = now_reg + 32'd1;
                lvl_next = LVW'(1);
            end
            S_CAS_RD:   bkt_ra = cas_b;
            S_CAS_CLR:
            begin
                bkt_we = 1'b1;
                bkt_wa = cas_b;
                bkt_wd = '{head: PTR_NIL, tail: PTR_NIL};
                t_next = bkt_q.tail;
            end
            S_CAS_WALK:
            begin
                if (ptr_ok(t_reg))
                begin
                    ent_ra = t_reg[EW-1:0];
                    e_next = t_reg[EW-1:0];
                end
                else if (!sts.cas_stop)
                    lvl_next = lvl_reg + LVW'(1);
                else if (cas_dig == '0)
                    pos_next = '0;
            end
            S_CAS_PICK:
            begin
                b_next = pick_bucket(rem, pos_reg);
                t_next = prv_q;
            end
            default:    bkt_we = 1'b0;
        endcase
    end

    // result register
    always_comb
    begin
        done_next = cmd.emit;
        res_next  = res_reg;
        if (cmd.emit)
        begin
            res_next.kind         = cmd.kind;
            res_next.status       = cmd.stat;
            res_next.active_count = cnt_reg;
            res_next.last         = cmd.last;
            case (cmd.id_src)
                ID_ENTRY:  res_next.timer_id = HDL_W'(e_reg);
                ID_HANDLE: res_next.timer_id = handle_reg;
                default:   res_next.timer_id = '0;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (bkt_we)
            bkt_mem[bkt_wa] <= bkt_wd;
        bkt_q <= bkt_mem[bkt_ra];
    end

    always_ff @(posedge clk)
    begin
        if (exp_we)
            exp_mem[exp_wa] <= exp_wd;
        exp_q <= exp_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (ebk_we)
            ebk_mem[ebk_wa] <= ebk_wd;
        ebk_q <= ebk_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (nxt_we)
            nxt_mem[nxt_wa] <= nxt_wd;
        nxt_q <= nxt_mem[ent_ra];
    end

    always_ff @(posedge clk)
    begin
        if (prv_we)
            prv_mem[prv_wa] <= prv_wd;
        prv_q <= prv_mem[ent_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= '0;
            cnt_reg    <= '0;
            pos_reg    <= '0;
            now_reg    <= '0;
            lvl_reg    <= '0;
            clr_reg    <= '0;
            done_reg   <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
            cnt_reg    <= cnt_next;
            pos_reg    <= pos_next;
            now_reg    <= now_next;
            lvl_reg    <= lvl_next;
            clr_reg    <= clr_next;
            done_reg   <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg    <= res_next;
        e_reg      <= e_next;
        b_reg      <= b_next;
        p_reg      <= p_next;
        n_reg      <= n_next;
        t_reg      <= t_next;
        delay_reg  <= delay_next;
        handle_reg <= handle_next;
    end

    assign done   = done_reg;
    assign result = res_reg;

endmodule
`default_nettype wire

// ----- design/hierarchical_timer_wheel.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// hierarchical_timer_wheel - multi-level timer wheel over a fixed timer pool
// Set, clear and tick requests; each result is strobed out with done.
// ----------------------------------------------------------------------------
// A request is taken when start is high and busy is low. Every result appears
// on result for one cycle with done high and must be captured then: there is
// no way to hold results off. After reset the bucket memory is swept to empty,
// one bucket per cycle, and busy stays high until the sweep is done. The
// bucket and entry memories have registered reads. A set stops early if the
// pool is full and a clear if the handle is not active; a tick unlinks each
// timer that expires and, on a level-0 wrap, cascades higher levels and
// moves their timers into new buckets.
// Expiring timers come out oldest first; last marks the final item of a
// request, and active_count is the pending total after that item.
// ----------------------------------------------------------------------------
module hierarchical_timer_wheel #(
    parameter int LEVEL_BITS = 8,
    parameter int NUM_LEVELS = 4,
    parameter int POOL_SIZE  = 64
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          start,
    output logic               busy,
    input  wire htw_pkg::req_t request,
    output logic               done,
    output htw_pkg::res_t      result
);
    import htw_pkg::*;

    cmd_t cmd;
    sts_t sts;

    // sequencer: one state per memory step
    htw_ctrl u_ctrl (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .req_op (request.op),
        .sts    (sts),
        .cmd    (cmd),
        .busy   (busy)
    );

    // memories, pool flags, wheel position and result register
    htw_dpath #(
        .LEVEL_BITS (LEVEL_BITS),
        .NUM_LEVELS (NUM_LEVELS),
        .POOL_SIZE  (POOL_SIZE)
    ) u_dpath (
        .clk     (clk),
        .rst_n   (rst_n),
        .request (request),
        .cmd     (cmd),
        .sts     (sts),
        .done    (done),
        .result  (result)
    );

endmodule
`default_nettype wire

// ----- bench/tb_hierarchical_timer_wheel.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_hierarchical_timer_wheel - self-checking bench for the timer wheel
// Drives set, clear and tick items through the start/busy handshake, keeps
// its own model of the wheel and checks every strobed result against it.
// ----------------------------------------------------------------------------
module tb_hierarchical_timer_wheel;
    import htw_pkg::*;

    localparam int LB     = 8;
    localparam int NLV    = 4;
    localparam int NPOOL  = 64;
    localparam int NBK    = 1 << LB;
    localparam int NALL   = NLV * NBK;
    localparam int NILP   = 127;
    // Quiet-cycle limit: covers the post-reset sweep and a worst-case tick
    // that fires the whole pool or cascades every pending timer.
    localparam int WATCHDOG = 20000;

    logic clk;
    logic rst_n;
    logic start;
    logic busy;
    req_t request;
    logic done;
    res_t result;

    hierarchical_timer_wheel DUT (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (start),
        .busy    (busy),
        .request (request),
        .done    (done),
        .result  (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // ---- wheel model ---------------------------------------------------------
    bit          tm_active [NPOOL];
    logic [31:0] tm_expiry [NPOOL];
    int          tm_bucket [NPOOL];
    int          tm_next   [NPOOL];
    int          tm_prev   [NPOOL];
    int          bk_head   [NALL];
    int          bk_tail   [NALL];
    logic [31:0] wheel_pos;
    logic [31:0] tick_count;
    int          pending;

    res_t expected_results[$];
    req_t pending_items[$];

    int  mismatches;
    int  quiet_cycles;

    function automatic int bucket_for(logic [63:0] ticks);
        int lvl;
        logic [63:0] idx;
        lvl = 0;
        idx = 0;
        while (lvl < NLV)
        begin
            if (ticks < (64'd1 << (LB * (lvl + 1))))
            begin
                idx = ticks >> (LB * lvl);
                break;
            end
            lvl++;
        end
        idx += ({32'd0, wheel_pos} >> (LB * lvl)) & (NBK - 1);
        if (idx >= NBK)
        begin
            lvl++;
            idx = 0;
        end
        if (lvl >= NLV)
        begin
            lvl = NLV - 1;
            idx = NBK - 1;
        end
        return lvl * NBK + int'(idx);
    endfunction

    function automatic void link_front(int b, int e);
        int h;
        h = bk_head[b];
        tm_prev[e] = NILP;
        tm_next[e] = h;
        if (h < NPOOL) tm_prev[h] = e;
        else bk_tail[b] = e;
        bk_head[b] = e;
        tm_bucket[e] = b;
    endfunction

    function automatic void unlink(int e);
        int b;
        int p;
        int n;
        b = tm_bucket[e];
        p = tm_prev[e];
        n = tm_next[e];
        if (p < NPOOL) tm_next[p] = n; else bk_head[b] = n;
        if (n < NPOOL) tm_prev[n] = p; else bk_tail[b] = p;
    endfunction

    function automatic void redistribute(int lvl, int idx);
        int b;
        int t;
        int p;
        logic [31:0] rem;
        b = lvl * NBK + idx;
        t = bk_tail[b];
        bk_head[b] = NILP;
        bk_tail[b] = NILP;
        while (t < NPOOL)
        begin
            p = tm_prev[t];
            rem = tm_expiry[t] - tick_count;
            if (rem == 0) rem = 1;
            link_front(bucket_for({32'd0, rem}), t);
            t = p;
        end
    endfunction

    function automatic void push_result(kind_t k, int id, stat_t st);
        res_t r;
        r.kind = k;
        r.timer_id = id[5:0];
        r.status = st;
        r.active_count = pending[6:0];
        r.last = 1'b0;
        expected_results.push_back(r);
    endfunction

    function automatic void wheel_step(req_t it);
        logic [31:0] dly;
        int e;
        int h;
        int b;
        int t;
        int n;
        int d;
        n = 0;
        if (it.op == OP_SET)
        begin
            dly = (it.delay_ticks < 1) ? 32'd1 : it.delay_ticks;
            for (e = 0; e < NPOOL; e++)
                if (!tm_active[e]) break;
            if (e >= NPOOL) push_result(KIND_SET, 0, STAT_FULL);
            else
            begin
                tm_active[e] = 1'b1;
                tm_expiry[e] = tick_count + dly;
                link_front(bucket_for({32'd0, dly}), e);
                pending++;
                push_result(KIND_SET, e, STAT_OK);
            end
        end
        else if (it.op == OP_CLEAR)
        begin
            h = int'(it.handle);
            if (h >= NPOOL || !tm_active[h]) push_result(KIND_CLEAR, h, STAT_NOT_ACTIVE);
            else
            begin
                unlink(h);
                tm_active[h] = 1'b0;
                pending--;
                push_result(KIND_CLEAR, h, STAT_OK);
            end
        end
        else
        begin
            // tick (an unknown op code behaves the same)
            b = wheel_pos & (NBK - 1);
            t = bk_tail[b];
            while (t < NPOOL && n < NPOOL)
            begin
                unlink(t);
                tm_active[t] = 1'b0;
                pending--;
                push_result(KIND_EXPIRED, t, STAT_OK);
                n++;
                t = bk_tail[b];
            end
            wheel_pos++;
            tick_count++;
            if ((wheel_pos & (NBK - 1)) == 0)
            begin
                for (int i = 1; i < NLV; i++)
                begin
                    d = (wheel_pos >> (LB * i)) & (NBK - 1);
                    redistribute(i, d);
                    if (d != 0) break;
                    if (i + 1 == NLV) wheel_pos = 0;
                end
            end
            if (n == 0) push_result(KIND_QUIET, 0, STAT_OK);
        end
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // ---- driver ----------------------------------------------------------------
    int   gap_left;
    logic taken;

    // an item is taken at a rising edge with start high and busy low
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) taken <= 1'b0;
        else taken <= start && !busy;
    end

    always @(negedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            start    <= 1'b0;
            request  <= '0;
            gap_left <= 0;
        end
        else if (taken)
        begin
            // item taken at the last rising edge
            wheel_step(request);
            void'(pending_items.pop_front());
            start    <= 1'b0;
            gap_left <= $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 11);
        end
        else if (!start && pending_items.size() > 0)
        begin
            if (gap_left > 0) gap_left <= gap_left - 1;
            else
            begin
                request <= pending_items[0];
                start   <= 1'b1;
            end
        end
    end

    // ---- monitor ---------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && done)
        begin
            if (expected_results.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %p", result);
            end
            else
            begin
                res_t exp_r;
                exp_r = expected_results.pop_front();
                if (exp_r !== result)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: expected %p, got %p", exp_r, result);
                end
            end
        end
    end

    // watchdog: counts cycles with nothing accepted on either side
    always @(posedge clk)
    begin
        if (!rst_n || done || (start && !busy)) quiet_cycles <= 0;
        else quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic req_t mk(op_t o, int d, int h);
        req_t r;
        r.op = o;
        r.delay_ticks = d;
        r.handle = h[5:0];
        return r;
    endfunction

    // ---- stimulus ----------------------------------------------------------
    initial
    begin
        req_t it;
        int   k;
        for (int i = 0; i < NPOOL; i++)
        begin
            tm_active[i] = 0;
            tm_expiry[i] = 0;
            tm_bucket[i] = 0;
            tm_next[i]   = NILP;
            tm_prev[i]   = NILP;
        end
        for (int i = 0; i < NALL; i++)
        begin
            bk_head[i] = NILP;
            bk_tail[i] = NILP;
        end
        wheel_pos  = 0;
        tick_count = 0;
        pending    = 0;
        rst_n   = 1'b0;
        repeat (5) @(posedge clk);
        @(negedge clk) rst_n = 1'b1;

        // directed: zero delay, one tick, same-bucket order, clears, extremes
        pending_items.push_back(mk(OP_TICK, 0, 0));               // quiet tick
        pending_items.push_back(mk(OP_SET, 0, 0));                // delay 0 -> 1
        pending_items.push_back(mk(OP_SET, 1, 0));
        pending_items.push_back(mk(OP_SET, 1, 0));
        pending_items.push_back(mk(OP_TICK, 32'hFFFF_FFFF, 63));
        pending_items.push_back(mk(OP_TICK, 0, 0));               // fires three oldest first
        pending_items.push_back(mk(OP_SET, 32'hFFFF_FFFF, 0));    // clamps to last bucket
        pending_items.push_back(mk(OP_SET, 255, 0));
        pending_items.push_back(mk(OP_SET, 256, 0));
        pending_items.push_back(mk(OP_SET, 32'h0001_0000, 0));
        pending_items.push_back(mk(OP_SET, 32'h0100_0000, 0));
        pending_items.push_back(mk(OP_CLEAR, 0, 1));
        pending_items.push_back(mk(OP_CLEAR, 0, 1));              // already inactive
        pending_items.push_back(mk(OP_CLEAR, 0, 63));
        pending_items.push_back(mk(OP_CLEAR, 0, 0));
        it = mk(OP_TICK, 0, 0);
        it.op = 2'd3;                                             // unknown op acts as tick
        pending_items.push_back(it);
        // fill the pool to hit the full case, then free part of it again
        for (int i = 0; i < NPOOL + 1; i++)
            pending_items.push_back(mk(OP_SET, $urandom_range(1, 600), 0));
        for (int i = 0; i < 16; i++)
            pending_items.push_back(mk(OP_CLEAR, 0, i * 4));

        // random: mostly short delays so timers fire and cascade across wraps
        for (int i = 0; i < 30; i++)
        begin
            k = $urandom_range(0, 9);
            if (k < 4)
            begin
                case ($urandom_range(0, 3))
                    0: it = mk(OP_SET, $urandom_range(0, 20), 0);
                    1: it = mk(OP_SET, $urandom_range(0, 700), 0);
                    2: it = mk(OP_SET, $urandom, 0);
                    default: it = mk(OP_SET, $urandom_range(0, 70000), 0);
                endcase
            end
            else if (k < 6) it = mk(OP_CLEAR, $urandom, $urandom_range(0, 63));
            else it = mk(OP_TICK, $urandom, $urandom_range(0, 63));
            if (k == 9) it.op = 2'd3;
            pending_items.push_back(it);
        end
        // run the wheel through a level-0 wrap so cascades happen
        for (int i = 0; i < 260; i++)
            pending_items.push_back(mk(OP_TICK, 0, 0));

        wait (pending_items.size() == 0);
        wait (expected_results.size() == 0);
        repeat (400) @(posedge clk);
        if (mismatches == 0 && expected_results.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end
endmodule
